@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL files.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(label, expr, msg)
`define ASSERT_IMPLIES(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

@@ sv/bpmc_pkg.sv @@
// Package for the button press mode controller: codes, widths, reset values.
// No dependencies.
package bpmc_pkg;

    localparam int TIMER_WIDTH_DEF    = 16;
    localparam int DISTANCE_WIDTH_DEF = 10;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int DEB_W       = 10;
    localparam int THR_W       = 16;
    localparam int BLIND_W     = 10;
    localparam int DIST_FIELD_W = 10;

    typedef logic [1:0] mode_t;
    localparam mode_t MODE_NORMAL = 2'd0;
    localparam mode_t MODE_CALIB  = 2'd1;
    localparam mode_t MODE_FILL   = 2'd2;

    typedef logic [1:0] req_t;
    localparam req_t REQ_NONE  = 2'd0;
    localparam req_t REQ_ENTER = 2'd1;
    localparam req_t REQ_EXIT  = 2'd2;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    localparam cfg_index_t REG_DEBOUNCE = 2'd0;
    localparam cfg_index_t REG_LONG     = 2'd1;
    localparam cfg_index_t REG_CLEAR    = 2'd2;
    localparam cfg_index_t REG_BLIND    = 2'd3;

    localparam logic [DEB_W-1:0]   DEBOUNCE_RST = 10'd50;
    localparam logic [THR_W-1:0]   LONG_RST     = 16'd2000;
    localparam logic [THR_W-1:0]   CLEAR_RST    = 16'd7000;
    localparam logic [BLIND_W-1:0] BLIND_RST    = 10'd20;

endpackage

@@ sv/button_press_mode_controller.sv @@
// Button press mode controller: debounce, press timing, mode and water requests.
// Depends on bpmc_pkg and assert_macros.svh.
// An accepted tick item's result is held in the output register from the following cycle.
// Throughput: one item per cycle while m_axis_tready is high; the single output register is refilled as it drains.
// Reset: mode normal, no request, button released, timers zero, base distance zero,
// configuration registers at 50 / 2000 / 7000 / 20.
`include "assert_macros.svh"

module button_press_mode_controller #(
    parameter int TIMER_WIDTH    = bpmc_pkg::TIMER_WIDTH_DEF,
    parameter int DISTANCE_WIDTH = bpmc_pkg::DISTANCE_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bpmc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bpmc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // button_level, level_low_event, level_restored_event, distance_cm
    input  logic [((DISTANCE_WIDTH+3+7)/8)*8-1:0] s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // mode[1:0], clear_pulse, saved_pulse, rejected_pulse, base_distance
    output logic [((DISTANCE_WIDTH+5+7)/8)*8-1:0] m_axis_tdata
);
    import bpmc_pkg::*;

    localparam int OUT_TW = ((DISTANCE_WIDTH + 5 + 7) / 8) * 8;
    localparam int DMW    = (DISTANCE_WIDTH < DIST_FIELD_W) ? DISTANCE_WIDTH : DIST_FIELD_W;
    localparam int CMP_W  = (TIMER_WIDTH > THR_W) ? TIMER_WIDTH : THR_W;
    localparam int DCMP_W = (DISTANCE_WIDTH > BLIND_W) ? DISTANCE_WIDTH : BLIND_W;
    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;

    logic [DEB_W-1:0]   debounce_ticks_reg;
    logic [THR_W-1:0]   long_press_reg;
    logic [THR_W-1:0]   clear_press_reg;
    logic [BLIND_W-1:0] blind_spot_reg;

    mode_t                     mode_reg, mode_next;
    req_t                      pending_reg, pending_next;
    logic                      stable_reg, stable_next;
    logic                      waiting_reg, waiting_next;
    logic [DEB_W-1:0]          left_reg, left_next;
    logic [TIMER_WIDTH-1:0]    press_reg, press_next;
    logic [DISTANCE_WIDTH-1:0] base_reg, base_next;

    logic                      out_valid_reg;
    mode_t                     out_mode_reg;
    logic                      out_clear_reg, out_saved_reg, out_rej_reg;
    logic [DISTANCE_WIDTH-1:0] out_base_reg;

    logic                      in_accept;
    logic                      raw, low_ev, rest_ev;
    logic [DISTANCE_WIDTH-1:0] dist_in;
    mode_t                     mode_a;
    logic [TIMER_WIDTH-1:0]    press_a;
    logic                      clear_p, saved_p, rej_p;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign raw     = s_axis_tdata[0];
    assign low_ev  = s_axis_tdata[1];
    assign rest_ev = s_axis_tdata[2];
    assign dist_in = DISTANCE_WIDTH'(s_axis_tdata[3 +: DMW]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg <= DEBOUNCE_RST;
            long_press_reg     <= LONG_RST;
            clear_press_reg    <= CLEAR_RST;
            blind_spot_reg     <= BLIND_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_DEBOUNCE: debounce_ticks_reg <= cfg_data[DEB_W-1:0];
                REG_LONG:     long_press_reg     <= cfg_data[THR_W-1:0];
                REG_CLEAR:    clear_press_reg    <= cfg_data[THR_W-1:0];
                REG_BLIND:    blind_spot_reg     <= cfg_data[BLIND_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        mode_a = mode_reg;
        if (pending_reg == REQ_ENTER)
        begin
            mode_a = MODE_FILL;
        end
        else if (pending_reg == REQ_EXIT)
        begin
            mode_a = MODE_NORMAL;
        end

        press_a = press_reg;
        if (!stable_reg && press_reg != TIMER_MAX)
        begin
            press_a = press_reg + TIMER_WIDTH'(1);
        end

        mode_next    = mode_a;
        pending_next = REQ_NONE;
        stable_next  = stable_reg;
        waiting_next = waiting_reg;
        left_next    = left_reg;
        press_next   = press_a;
        base_next    = base_reg;
        clear_p      = 1'b0;
        saved_p      = 1'b0;
        rej_p        = 1'b0;

        if (mode_a == MODE_FILL)
        begin
            waiting_next = 1'b0;
            left_next    = '0;
        end
        else if (waiting_reg)
        begin
            left_next = (left_reg != '0) ? left_reg - DEB_W'(1) : left_reg;
            if (left_next == '0)
            begin
                waiting_next = 1'b0;
                if (raw != stable_reg)
                begin
                    stable_next = raw;
                    if (!raw)
                    begin
                        press_next = '0;
                    end
                    else if (CMP_W'(press_a) >= CMP_W'(clear_press_reg))
                    begin
                        clear_p      = 1'b1;
                        mode_next    = MODE_NORMAL;
                        stable_next  = 1'b1;
                        waiting_next = 1'b0;
                        left_next    = '0;
                        press_next   = '0;
                        base_next    = '0;
                    end
                    else if (CMP_W'(press_a) >= CMP_W'(long_press_reg))
                    begin
                        mode_next = MODE_CALIB;
                    end
                    else if (mode_a == MODE_CALIB)
                    begin
                        if (DCMP_W'(dist_in) > DCMP_W'(blind_spot_reg))
                        begin
                            base_next = dist_in;
                            mode_next = MODE_NORMAL;
                            saved_p   = 1'b1;
                        end
                        else
                        begin
                            rej_p = 1'b1;
                        end
                    end
                end
            end
        end
        else if (raw != stable_reg)
        begin
            waiting_next = 1'b1;
            left_next    = (debounce_ticks_reg != '0) ? debounce_ticks_reg : DEB_W'(1);
        end

        if (!clear_p)
        begin
            if (low_ev && mode_next != MODE_FILL)
            begin
                pending_next = REQ_ENTER;
            end
            else if (rest_ev && mode_next == MODE_FILL)
            begin
                pending_next = REQ_EXIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_NORMAL;
            pending_reg <= REQ_NONE;
            stable_reg  <= 1'b1;
            waiting_reg <= 1'b0;
            left_reg    <= '0;
            press_reg   <= '0;
            base_reg    <= '0;
        end
        else if (in_accept)
        begin
            mode_reg    <= mode_next;
            pending_reg <= pending_next;
            stable_reg  <= stable_next;
            waiting_reg <= waiting_next;
            left_reg    <= left_next;
            press_reg   <= press_next;
            base_reg    <= base_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            out_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_mode_reg  <= mode_next;
            out_clear_reg <= clear_p;
            out_saved_reg <= saved_p;
            out_rej_reg   <= rej_p;
            out_base_reg  <= base_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TW'({out_base_reg, out_rej_reg, out_saved_reg,
                                    out_clear_reg, out_mode_reg});

    `ASSERT_IMPLIES(a_one_pulse, out_valid_reg,
        $countones({out_clear_reg, out_saved_reg, out_rej_reg}) <= 1,
        "more than one pulse in one result item")
    `ASSERT_IMPLIES(a_clear_resets, out_valid_reg && out_clear_reg,
        out_mode_reg == MODE_NORMAL && out_base_reg == '0,
        "clear item without reset state")
    `ASSERT_IMPLIES(a_enter_req, pending_reg == REQ_ENTER, mode_reg != MODE_FILL,
        "enter request filed while in fill mode")
    `ASSERT_IMPLIES(a_exit_req, pending_reg == REQ_EXIT, mode_reg == MODE_FILL,
        "exit request filed outside fill mode")
    `ASSERT_IMPLIES(a_idle_count, !waiting_reg, left_reg == '0,
        "debounce count left over with no wait in progress")
    `ASSERT_NEXT(a_accept_result, in_accept, out_valid_reg,
        "accepted item gave no result")

endmodule
